>>> rtl/fsnr_pkg.sv
// shared types and constants for the float square root block
`default_nettype none
package fsnr_pkg;
  localparam int FIX_W = 25;
  typedef logic [FIX_W-1:0] fix_t;
  localparam fix_t FIX_ONE = 25'h100_0000;
  localparam int DIV_STEPS = 27;
  localparam int DIV_CNT_W = 5;
  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] POS_INF_BITS = 32'h7F80_0000;
endpackage
`default_nettype wire

>>> rtl/float_square_root_newton.sv
// top level: binary32 square root by newton iteration on a bit-serial divider
// usage: s_tdata carries one binary32 operand, taken when s_tvalid and s_tready
//   are high at a rising edge of clk; m_tdata carries the binary32 root and
//   m_tuser flags invalid and hit_limit; one result per request, in order
// sequence from the accepting edge to m_tvalid high:
//   zero, infinity, nan and negative operands: straight to the output register
//   others: normalizing (one shift per cycle for a subnormal), start estimate,
//   then per newton step a divider start, 27 quotient bits, the divider done
//   flag and an add and round, at most MAX_ITERATIONS steps, then scaling and
//   the output register
// throughput: one request at a time; s_tready is high only while the core is
//   idle, so a new request can be taken in the cycle after the result loads
// reset: rst is synchronous, active high; clears the controller and m_tvalid
// stall: a finished result sits in the output register while m_tready is low;
//   the core takes the next request and stops before its own output only
//   if the previous result has still not been taken
`default_nettype none
module float_square_root_newton #(
  parameter int MAX_ITERATIONS = 8
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // [31:0] operand_bits
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // [31:0] root_bits
  output logic [1:0]  m_tuser    // [0] invalid, [1] hit_limit
);
  import fsnr_pkg::*;

  localparam int CW = $clog2(MAX_ITERATIONS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_NORM   = 3'd1;
  localparam logic [2:0] ST_INIT   = 3'd2;
  localparam logic [2:0] ST_DSTART = 3'd3;
  localparam logic [2:0] ST_DWAIT  = 3'd4;
  localparam logic [2:0] ST_ADD    = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;
  localparam logic [2:0] ST_RES    = 3'd7;

  logic [2:0]        state;
  logic [23:0]       n_sh;      // significand being normalized
  logic signed [8:0] e_reg;     // exponent of the split mantissa
  logic signed [8:0] half;      // half of the even exponent
  fix_t              m_fix;     // mantissa in [0.5,2), lsb 2^-24
  fix_t              a_fix;     // current estimate
  logic [CW-1:0]     count;
  logic [31:0]       res_root;
  logic              res_inv;
  logic              res_hit;

  logic              accept;
  logic [7:0]        field;
  logic [22:0]       frac;
  logic [7:0]        field_nz;
  logic signed [8:0] e_even;
  fix_t              add_a;
  fix_t              add_b;
  fix_t              add_out;
  logic              div_start;
  logic              div_busy;
  logic              div_done;
  fix_t              div_quo;
  logic [CW-1:0]     count_next;
  logic signed [9:0] exp_w;
  logic              out_free;

  assign accept = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign field = s_tdata[30:23];
  assign frac = s_tdata[22:0];
  assign field_nz = (field == 8'd0) ? 8'd1 : field;
  assign e_even = e_reg - $signed({8'b0, e_reg[0]});
  assign div_start = (state == ST_DSTART);
  assign count_next = count + 1'b1;
  assign out_free = !m_tvalid || m_tready;
  // start estimate is (1+m)/2 through the same rounding adder
  assign add_a = (state == ST_INIT) ? FIX_ONE : a_fix;
  assign add_b = (state == ST_INIT) ? m_fix : div_quo;
  assign exp_w = {half[8], half} + (a_fix[FIX_W-1] ? 10'sd127 : 10'sd126);

  fsnr_addh u_addh (
    .op_a     (add_a),
    .op_b     (add_b),
    .sum_half (add_out)
  );

  fsnr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (m_fix),
    .den   (a_fix),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // a new result loaded in ST_RES takes precedence over the drain
      if (m_tvalid && m_tready && state != ST_RES) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_hit <= 1'b0;
            if (s_tdata[30:0] == 31'd0) begin
              res_root <= 32'd0;
              res_inv <= 1'b0;
              state <= ST_RES;
            end else if (field == 8'hFF && frac != 23'd0) begin
              res_root <= QNAN_BITS;
              res_inv <= 1'b1;
              state <= ST_RES;
            end else if (s_tdata[31]) begin
              res_root <= QNAN_BITS;
              res_inv <= 1'b1;
              state <= ST_RES;
            end else if (field == 8'hFF) begin
              res_root <= POS_INF_BITS;
              res_inv <= 1'b0;
              state <= ST_RES;
            end else begin
              res_inv <= 1'b0;
              n_sh <= {field != 8'd0, frac};
              e_reg <= $signed({1'b0, field_nz}) - 9'sd126;
              state <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          // one left shift per cycle until the leading one reaches the top
          if (n_sh[23]) begin
            m_fix <= e_reg[0] ? {n_sh, 1'b0} : {1'b0, n_sh};
            half <= e_even >>> 1;
            state <= ST_INIT;
          end else begin
            n_sh <= {n_sh[22:0], 1'b0};
            e_reg <= e_reg - 9'sd1;
          end
        end
        ST_INIT: begin
          a_fix <= add_out;
          count <= '0;
          state <= ST_DSTART;
        end
        ST_DSTART: begin
          state <= ST_DWAIT;
        end
        ST_DWAIT: begin
          if (div_done) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          a_fix <= add_out;
          count <= count_next;
          if (add_out == a_fix) begin
            res_hit <= 1'b0;
            state <= ST_FIN;
          end else if (count_next == CW'(MAX_ITERATIONS)) begin
            res_hit <= 1'b1;
            state <= ST_FIN;
          end else begin
            state <= ST_DSTART;
          end
        end
        ST_FIN: begin
          // scaling by a power of two only moves the exponent
          res_root <= {1'b0, exp_w[7:0],
                       a_fix[FIX_W-1] ? a_fix[23:1] : a_fix[22:0]};
          state <= ST_RES;
        end
        ST_RES: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata <= res_root;
            m_tuser <= {res_hit, res_inv};
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_inv_nan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == QNAN_BITS)
    else $error("invalid result without quiet nan");
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("invalid and hit_limit both set");
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_busy)
    else $error("divider busy while idle");
  a_add_after_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_ADD |-> $past(div_done))
    else $error("add step without quotient");
endmodule
`default_nettype wire

>>> rtl/fsnr_addh.sv
// binary32 round-to-nearest-even add of two fixed operands, then halve
`default_nettype none
module fsnr_addh (
  input  wire fsnr_pkg::fix_t op_a,
  input  wire fsnr_pkg::fix_t op_b,
  output fsnr_pkg::fix_t      sum_half
);
  import fsnr_pkg::*;

  logic [FIX_W:0]   sum;
  logic [FIX_W-2:0] base;
  logic             up;
  logic [FIX_W-1:0] rnd;

  always_comb begin
    sum = {1'b0, op_a} + {1'b0, op_b};
    if (sum[FIX_W]) begin
      // sum in [2,4): grid of four units
      base = sum[FIX_W:2];
      up = sum[1] & (sum[0] | sum[2]);
    end else begin
      // sum in [1,2): grid of two units
      base = sum[FIX_W-1:1];
      up = sum[0] & sum[1];
    end
    rnd = {1'b0, base} + {{(FIX_W-1){1'b0}}, up};
    sum_half = sum[FIX_W] ? {rnd[FIX_W-2:0], 1'b0} : rnd;
  end
endmodule
`default_nettype wire

>>> rtl/fsnr_div.sv
// bit-serial restoring divider with binary32 rounding of the quotient
`default_nettype none
module fsnr_div (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire fsnr_pkg::fix_t num,
  input  wire fsnr_pkg::fix_t den,
  output logic                busy,
  output logic                done,
  output fsnr_pkg::fix_t      quo
);
  import fsnr_pkg::*;

  logic [FIX_W:0]     rem;
  logic [DIV_STEPS-1:0] qraw;
  logic [DIV_CNT_W-1:0] cnt;
  fix_t               den_q;
  logic [FIX_W:0]     diff;
  logic               ge;
  logic [FIX_W:0]     rem_next;
  logic [FIX_W-2:0]   base;
  logic               up;
  logic [FIX_W-1:0]   rnd;
  logic               sticky;

  always_comb begin
    ge = rem >= {1'b0, den_q};
    diff = rem - {1'b0, den_q};
    rem_next = ge ? {diff[FIX_W-1:0], 1'b0} : {rem[FIX_W-1:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        busy <= (cnt != DIV_CNT_W'(1));
        done <= (cnt == DIV_CNT_W'(1));
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, num};
      den_q <= den;
      qraw <= '0;
    end else if (busy) begin
      rem <= rem_next;
      qraw <= {qraw[DIV_STEPS-2:0], ge};
    end
  end

  // quotient carries two extra low bits below the fix_t lsb; remainder gives the sticky bit
  always_comb begin
    sticky = rem != '0;
    if (qraw[DIV_STEPS-1]) begin
      base = qraw[DIV_STEPS-1:3];
      up = qraw[2] & (qraw[1] | qraw[0] | sticky | qraw[3]);
    end else begin
      base = qraw[DIV_STEPS-2:2];
      up = qraw[1] & (qraw[0] | sticky | qraw[2]);
    end
    rnd = {1'b0, base} + {{(FIX_W-1){1'b0}}, up};
    quo = qraw[DIV_STEPS-1] ? {rnd[FIX_W-2:0], 1'b0} : rnd;
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
endmodule
`default_nettype wire

>>> tb/sv/tb_float_square_root_newton.sv
// self-checking testbench for the newton float square root block
`default_nettype none

typedef struct {
  logic [31:0] root;
  logic        invalid;
  logic        hit_limit;
} root_result_t;

class root_scoreboard;
  root_result_t pending[$];
  int errors;
  int checked;
  int max_iter;

  function new(int iters);
    errors = 0;
    checked = 0;
    max_iter = iters;
  endfunction

  // round a real (normal range only) to binary32 with nearest-even, return pattern
  function logic [31:0] to_f32(real v);
    logic [63:0] d;
    logic [23:0] mant;
    logic [28:0] rest;
    logic [24:0] sum;
    int ex;
    d = $realtobits(v);
    if (d[62:0] == 63'd0) return 32'd0;
    ex = int'(d[62:52]) - 1023 + 127;
    mant = {1'b1, d[51:29]};
    rest = d[28:0];
    sum = {1'b0, mant};
    if (rest > 29'h1000_0000 || (rest == 29'h1000_0000 && mant[0])) sum = sum + 25'd1;
    if (sum[24]) begin
      ex = ex + 1;
      sum = sum >> 1;
    end
    return {d[63], ex[7:0], sum[22:0]};
  endfunction

  function real from_f32(logic [31:0] b);
    logic [10:0] ex;
    if (b[30:0] == 31'd0) return 0.0;
    ex = 11'(int'(b[30:23]) - 127 + 1023);
    return $bitstoreal({b[31], ex, b[22:0], 29'd0});
  endfunction

  // rounded float ops, done in double then rounded once
  function real rnd(real v);
    return from_f32(to_f32(v));
  endfunction

  function root_result_t predict_root(logic [31:0] x);
    root_result_t r;
    logic [22:0] frac;
    logic [31:0] abits;
    int lead, e, half, count;
    real m, a, prev, q, s;
    r.root = 32'd0;
    r.invalid = 1'b0;
    r.hit_limit = 1'b0;
    frac = x[22:0];
    if (x[30:0] == 31'd0) return r;
    if (x[30:23] == 8'hFF && frac != 23'd0) begin
      r.root = fsnr_pkg::QNAN_BITS;
      r.invalid = 1'b1;
      return r;
    end
    if (x[31]) begin
      r.root = fsnr_pkg::QNAN_BITS;
      r.invalid = 1'b1;
      return r;
    end
    if (x[30:23] == 8'hFF) begin
      r.root = fsnr_pkg::POS_INF_BITS;
      return r;
    end
    if (x[30:23] == 8'h00) begin
      // subnormal: shift leading one out to make it normal
      lead = 22;
      while (lead > 0 && !frac[lead]) lead--;
      e = lead - 148;
      frac = frac << (23 - lead);
    end else begin
      e = int'(x[30:23]) - 126;
    end
    m = from_f32({9'd126 << 0 == 9'd126 ? 1'b0 : 1'b0, 8'd126, frac});
    if ((e & 1) != 0) begin
      e = e - 1;
      m = m * 2.0;
    end
    a = rnd((1.0 + m) * 0.5);
    prev = 0.0;
    count = 0;
    while (count < max_iter && a != prev) begin
      prev = a;
      q = rnd(m / a);
      s = rnd(a + q);
      a = s * 0.5;
      count++;
    end
    half = e / 2;
    abits = to_f32(a);
    abits[30:23] = 8'(int'(abits[30:23]) + half);
    r.root = abits;
    r.hit_limit = (a != prev);
    return r;
  endfunction

  function void note_operand(logic [31:0] x);
    pending.push_back(predict_root(x));
  endfunction

  function void check_root(logic [31:0] data, logic [1:0] user);
    root_result_t want;
    if (pending.size() == 0) begin
      $error("result 0x%08h arrived with nothing expected", data);
      errors++;
      return;
    end
    want = pending.pop_front();
    checked++;
    if (data !== want.root) begin
      $error("root_bits: expected 0x%08h actual 0x%08h", want.root, data);
      errors++;
    end
    if (user[0] !== want.invalid) begin
      $error("invalid: expected %0b actual %0b", want.invalid, user[0]);
      errors++;
    end
    if (user[1] !== want.hit_limit) begin
      $error("hit_limit: expected %0b actual %0b", want.hit_limit, user[1]);
      errors++;
    end
  endfunction
endclass

module tb_float_square_root_newton;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ITER = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = 32'd0;   // [31:0] operand_bits
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [31:0] root_bits
  logic [1:0]  m_tuser;           // [0] invalid, [1] hit_limit

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent = 0;

  root_scoreboard sb = new(MAX_ITER);

  float_square_root_newton #(.MAX_ITERATIONS(MAX_ITER)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watch both handshakes and toggle the receiver's ready
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_operand(s_tdata);
      if (m_tvalid && m_tready) sb.check_root(m_tdata, m_tuser);
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one request; random idle cycles before it
  task automatic send_operand(logic [31:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // mostly positive normals, some subnormals, some raw patterns
  function automatic logic [31:0] random_operand();
    int pick;
    pick = $urandom_range(99);
    if (pick < 65) return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom())};
    if (pick < 80) return {9'd0, 23'($urandom() >> $urandom_range(0, 22))};
    return $urandom();
  endfunction

  logic [31:0] directed [$] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
    32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
    32'h0000_0001, 32'h007F_FFFF, 32'h0040_0000, 32'h8000_0001,
    32'h7F7F_FFFF, 32'h0080_0000, 32'h3F80_0000, 32'h4000_0000,
    32'h4080_0000, 32'h3F00_0000, 32'h3E80_0000, 32'h4110_0000,
    32'hBF80_0000, 32'h3F7F_FFFF, 32'h4040_0000, 32'h0000_0002
  };

  initial begin
    int phase;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_operand(directed[i]);

    // three idling patterns: sender light/receiver heavy, swapped, none
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 46 : 0;
      recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 12 : 0;
      repeat (575) send_operand(random_operand());
    end
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("sent %0d operands (zeros, infinities, nans, negatives, subnormals, normals)",
             sent);
    $display("checked %0d roots under three handshake idling patterns", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("float_square_root_newton test passed");
    end else begin
      $display("float_square_root_newton test failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("float_square_root_newton test failed");
    $finish;
  end
endmodule
